[rtl/core/diagonal_span_chainer_defines.svh]
// ----------------------------------------------------------------------------
// diagonal span chainer assertion macros
// shared assertion forms, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DIAGONAL_SPAN_CHAINER_DEFINES_SVH
`define DIAGONAL_SPAN_CHAINER_DEFINES_SVH

`ifndef SYNTH
// property checked on every clock edge outside reset
`define DSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition in one cycle implies a consequence in the next
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	`DSC_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define DSC_ASSERT(lbl, prop, msg)
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/dsc_pkg.sv]
// ----------------------------------------------------------------------------
// dsc_pkg
// types, constants and helpers of the diagonal span chainer
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int POS_W  = 20;
	localparam int LEN_W  = 21;
	localparam int TOT_W  = 25;
	localparam int DIAG_W = 21;
	localparam int KEY_W  = DIAG_W + POS_W;
	localparam int PT_W   = 2 * POS_W;
	localparam logic [TOT_W-1:0] TOTAL_CAP = 25'h100_0000;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [POS_W-1:0] q_first;
		logic [POS_W-1:0] q_last;
		logic [POS_W-1:0] d_first;
		logic [POS_W-1:0] d_last;
	} span_t;

	typedef struct packed {
		logic load;       // point transaction accepted
		logic doc_start;  // final point accepted
		logic doc_done;   // last result delivered
		logic scan_start;
		logic scan_run;
		logic chain;
		logic close;
		logic sum_clear;
		logic sum_step;
		logic idx_inc;
		logic idx_clear;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic best_found;
		logic list_empty;
		logic idx_last;
	} sts_t;

	// span a ranks ahead of span b: longer, then lower q_first, then lower d_first
	function automatic logic ranks_before(span_t a, span_t b);
		logic r;
		if (a.len != b.len) r = a.len > b.len;
		else if (a.q_first != b.q_first) r = a.q_first < b.q_first;
		else r = a.d_first < b.d_first;
		return r;
	endfunction

endpackage

[rtl/core/dsc_ram.sv]
// ----------------------------------------------------------------------------
// dsc_ram
// simple dual-port memory, one write and one registered read port
// ----------------------------------------------------------------------------
module dsc_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/dsc_span_list.sv]
// ----------------------------------------------------------------------------
// dsc_span_list
// ranked list of the best spans, insertion by parallel compare and shift
// ----------------------------------------------------------------------------
`include "diagonal_span_chainer_defines.svh"

module dsc_span_list
	import dsc_pkg::*;
#(
	parameter int MAX_SPANS = 16,
	parameter int LIM_W     = $clog2(MAX_SPANS + 1),
	parameter int IDX_W     = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              offer,
	input  span_t             offer_span,
	input  logic [LEN_W-1:0]  min_len,
	input  logic [LIM_W-1:0]  limit,
	input  logic [IDX_W-1:0]  rd_idx,
	output span_t             rd_span,
	output logic [LIM_W-1:0]  cnt
);

	span_t             ent_q [MAX_SPANS];
	span_t             src   [MAX_SPANS];
	logic [MAX_SPANS-1:0] wins;
	logic [LIM_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  last_idx;
	logic              accept;

	always_comb begin
		for (int i = 0; i < MAX_SPANS; i++) begin
			wins[i] = (LIM_W'(i) >= cnt_q) || ranks_before(offer_span, ent_q[i]);
		end
		src[0] = offer_span;
		for (int i = 1; i < MAX_SPANS; i++) begin
			src[i] = wins[i-1] ? ent_q[i-1] : offer_span;
		end
		last_idx = IDX_W'(limit - LIM_W'(1));
		accept = offer && (offer_span.len >= min_len) && (limit != '0) &&
			((cnt_q < limit) || wins[last_idx]);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_SPANS; i++) begin
			if (accept && wins[i]) ent_q[i] <= src[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (accept && (cnt_q < limit)) begin
			cnt_q <= cnt_q + LIM_W'(1);
		end
	end

	assign rd_span = ent_q[rd_idx];
	assign cnt     = cnt_q;

	`DSC_ASSERT_NEXT(a_cnt_within_limit, accept, cnt_q <= $past(limit), "span count above limit")
	`DSC_ASSERT_NEXT(a_cnt_grows_by_one, !clear, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + LIM_W'(1)), "span count jumped")

endmodule

[rtl/core/dsc_datapath.sv]
// ----------------------------------------------------------------------------
// dsc_datapath
// point memory, minimum-key scan, diagonal chaining and result totals
// ----------------------------------------------------------------------------
module dsc_datapath
	import dsc_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_SPANS  = 16,
	parameter int LIM_W      = $clog2(MAX_SPANS + 1),
	parameter int IDX_W      = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [POS_W-1:0] query_pos,
	input  logic [POS_W-1:0] doc_pos,
	input  logic [7:0]       merge_gap,
	input  logic [LEN_W-1:0] min_span_length,
	input  logic [LIM_W-1:0] limit,
	output logic             span_valid,
	output span_t            out_span,
	output logic [TOT_W-1:0] matched_total,
	output logic             points_dropped
);

	localparam int AW     = $clog2(MAX_POINTS);
	localparam int PCNT_W = $clog2(MAX_POINTS + 1);

	logic [PCNT_W-1:0] pcnt_q, raddr_q;
	logic              ovf_q, rvld_q, rd_en, wr_en;
	logic [PT_W-1:0]   rd_pt;
	logic [DIAG_W-1:0] c_diag;
	logic [KEY_W-1:0]  c_key, best_q, prev_q;
	logic              found_q, have_prev_q, better;

	logic              open_q, merge, offer;
	logic [DIAG_W-1:0] cur_diag_q, b_diag;
	logic [POS_W-1:0]  qs_q, qe_q, ds_q, de_q, b_q, b_d;
	span_t             offer_span, rd_span;
	logic [LIM_W-1:0]  span_cnt;
	logic [IDX_W-1:0]  idx_q;
	logic [TOT_W-1:0]  acc_q;
	logic [TOT_W:0]    acc_sum;

	// point memory
	assign wr_en = cmd.load && (pcnt_q < PCNT_W'(MAX_POINTS));
	assign rd_en = cmd.scan_run && (raddr_q < pcnt_q);

	dsc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS), .AW(AW)) u_points (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pcnt_q[AW-1:0]),
		.wdata ({doc_pos, query_pos}),
		.re    (rd_en),
		.raddr (raddr_q[AW-1:0]),
		.rdata (rd_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.doc_done) begin
			pcnt_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.load) begin
			if (wr_en) pcnt_q <= pcnt_q + PCNT_W'(1);
			else ovf_q <= 1'b1;
		end
	end

	// scan for the smallest key above the last one taken
	assign c_diag = DIAG_W'(({2'b00, rd_pt[PT_W-1:POS_W]} + 22'h10_0000) -
		{2'b00, rd_pt[POS_W-1:0]});
	assign c_key  = {c_diag, rd_pt[POS_W-1:0]};
	assign better = (!have_prev_q || (c_key > prev_q)) && (!found_q || (c_key < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raddr_q     <= '0;
			rvld_q      <= 1'b0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			rvld_q <= rd_en;
			if (cmd.scan_start) begin
				raddr_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) raddr_q <= raddr_q + PCNT_W'(1);
				if (rvld_q && better) found_q <= 1'b1;
			end
			if (cmd.doc_start) have_prev_q <= 1'b0;
			else if (cmd.chain) have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_q && better && !cmd.scan_start) best_q <= c_key;
		if (cmd.chain) prev_q <= best_q;
	end

	// chaining along the diagonal
	assign b_q    = best_q[POS_W-1:0];
	assign b_diag = best_q[KEY_W-1:POS_W];
	assign b_d    = POS_W'({1'b0, b_diag[POS_W-1:0]} + {1'b0, b_q});
	assign merge  = open_q && (b_diag == cur_diag_q) &&
		({2'b00, b_q} <= ({2'b00, qe_q} + 22'd1 + {14'd0, merge_gap})) &&
		({2'b00, b_d} <= ({2'b00, de_q} + 22'd1 + {14'd0, merge_gap}));
	assign offer  = open_q && ((cmd.chain && !merge) || cmd.close);

	always_comb begin
		offer_span.len     = LEN_W'({1'b0, qe_q} - {1'b0, qs_q} + 21'd1);
		offer_span.q_first = qs_q;
		offer_span.q_last  = qe_q;
		offer_span.d_first = ds_q;
		offer_span.d_last  = de_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (cmd.doc_start) begin
			open_q <= 1'b0;
		end else if (cmd.chain) begin
			open_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chain) begin
			if (merge) begin
				if (b_q > qe_q) qe_q <= b_q;
				if (b_d > de_q) de_q <= b_d;
			end else begin
				cur_diag_q <= b_diag;
				qs_q <= b_q;
				qe_q <= b_q;
				ds_q <= b_d;
				de_q <= b_d;
			end
		end
	end

	dsc_span_list #(.MAX_SPANS(MAX_SPANS), .LIM_W(LIM_W), .IDX_W(IDX_W)) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cmd.doc_start),
		.offer      (offer),
		.offer_span (offer_span),
		.min_len    (min_span_length),
		.limit      (limit),
		.rd_idx     (idx_q),
		.rd_span    (rd_span),
		.cnt        (span_cnt)
	);

	// totals and result index
	assign acc_sum = {1'b0, acc_q} + (TOT_W+1)'(rd_span.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.idx_clear) idx_q <= '0;
			else if (cmd.idx_inc || cmd.sum_step) idx_q <= idx_q + IDX_W'(1);
			if (cmd.sum_clear) acc_q <= '0;
			else if (cmd.sum_step) begin
				acc_q <= (acc_sum > (TOT_W+1)'(TOTAL_CAP)) ? TOTAL_CAP : acc_sum[TOT_W-1:0];
			end
		end
	end

	assign sts.scan_done  = (raddr_q == pcnt_q) && !rvld_q;
	assign sts.best_found = found_q;
	assign sts.list_empty = (span_cnt == '0);
	assign sts.idx_last   = ((LIM_W'(idx_q) + LIM_W'(1)) == span_cnt);

	assign span_valid     = !sts.list_empty;
	assign out_span       = sts.list_empty ? '0 : rd_span;
	assign matched_total  = acc_q;
	assign points_dropped = ovf_q;

endmodule

[rtl/core/dsc_ctrl.sv]
// ----------------------------------------------------------------------------
// dsc_ctrl
// sequencer: load, scan and chain passes, totals, result delivery
// ----------------------------------------------------------------------------
`include "diagonal_span_chainer_defines.svh"

module dsc_ctrl
	import dsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tlast,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output logic m_tlast,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [2:0] S_LOAD    = 3'd0;
	localparam logic [2:0] S_SCAN_GO = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_CHAIN   = 3'd3;
	localparam logic [2:0] S_CLOSE   = 3'd4;
	localparam logic [2:0] S_SUM     = 3'd5;
	localparam logic [2:0] S_OUT     = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		m_tlast  = sts.list_empty || sts.idx_last;
		unique case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tlast) begin
						cmd.doc_start = 1'b1;
						state_d = S_SCAN_GO;
					end
				end
			end
			S_SCAN_GO: begin
				cmd.scan_start = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) state_d = sts.best_found ? S_CHAIN : S_CLOSE;
			end
			S_CHAIN: begin
				cmd.chain = 1'b1;
				state_d = S_SCAN_GO;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				cmd.sum_clear = 1'b1;
				cmd.idx_clear = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				if (sts.list_empty) begin
					state_d = S_OUT;
				end else begin
					cmd.sum_step = 1'b1;
					if (sts.idx_last) begin
						cmd.idx_clear = 1'b1;
						state_d = S_OUT;
					end
				end
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (m_tlast) begin
						cmd.doc_done = 1'b1;
						state_d = S_LOAD;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else state_q <= state_d;
	end

	`DSC_ASSERT_NEXT(a_final_starts_scan, s_tvalid && s_tready && s_tlast, state_q == S_SCAN_GO, "final point did not start a scan")
	`DSC_ASSERT_NEXT(a_found_goes_chain, (state_q == S_SCAN) && sts.scan_done && sts.best_found, state_q == S_CHAIN, "found point not chained")
	`DSC_ASSERT_NEXT(a_eol_reopens_input, m_tvalid && m_tready && m_tlast, s_tready, "input not reopened after end of list")

endmodule

[rtl/core/diagonal_span_chainer.sv]
// ----------------------------------------------------------------------------
// diagonal_span_chainer
// chains one document's match points into ranked diagonal spans
// ----------------------------------------------------------------------------
// Points stream in at one transaction per cycle until a point with tlast;
// points past MAX_POINTS are dropped and flagged. After the last point the
// block stops taking input and sorts by repeated passes over the point
// memory through its single read port: each pass restarts the scan, reads
// every stored point, drains the registered read and finds the next larger
// (diagonal, query) key; each pass that finds one is followed by chaining
// that point. Closing the last open span and summing the kept span lengths
// follow, then one result per cycle as the sink takes them, the last marked
// with tlast.
// No clearing pass after reset is needed.
module diagonal_span_chainer
	import dsc_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_SPANS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// point input
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // query_pos[19:0], doc_pos[39:20]
	input  logic         s_tlast,   // final_point
	// span results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // q_first, q_last, d_first, d_last, span_len,
	                                // matched_total, points_dropped, zero pad
	output logic         m_tuser,   // span_valid
	output logic         m_tlast,   // end_of_list
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int LIM_W = $clog2(MAX_SPANS + 1);
	localparam int IDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;

	// register index codes
	localparam logic [1:0] REG_MERGE_GAP = 2'd0;
	localparam logic [1:0] REG_MIN_LEN   = 2'd1;
	localparam logic [1:0] REG_MAX_SPANS = 2'd2;

	logic [7:0]       merge_gap_q;
	logic [LEN_W-1:0] min_len_q;
	logic [4:0]       max_spans_q;
	logic [LIM_W-1:0] limit;
	logic             wr_cfg;

	cmd_t             cmd;
	sts_t             sts;
	span_t            out_span;
	logic             span_valid, points_dropped;
	logic [TOT_W-1:0] matched_total;

	// apb register file, writes land on the access cycle
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_gap_q <= 8'd0;
			min_len_q   <= LEN_W'(1);
			max_spans_q <= 5'd16;
		end else if (wr_cfg) begin
			unique case (paddr[3:2])
				REG_MERGE_GAP: merge_gap_q <= pwdata[7:0];
				REG_MIN_LEN:   min_len_q   <= pwdata[LEN_W-1:0];
				REG_MAX_SPANS: max_spans_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MERGE_GAP: prdata = {24'd0, merge_gap_q};
			REG_MIN_LEN:   prdata = {11'd0, min_len_q};
			REG_MAX_SPANS: prdata = {27'd0, max_spans_q};
			default:       prdata = 32'd0;
		endcase
	end

	// requested list length clipped to the list capacity
	assign limit = (32'(max_spans_q) > MAX_SPANS) ? LIM_W'(MAX_SPANS) : LIM_W'(max_spans_q);

	dsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.sts      (sts)
	);

	dsc_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_SPANS  (MAX_SPANS),
		.LIM_W      (LIM_W),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.query_pos       (s_tdata[19:0]),
		.doc_pos         (s_tdata[39:20]),
		.merge_gap       (merge_gap_q),
		.min_span_length (min_len_q),
		.limit           (limit),
		.span_valid      (span_valid),
		.out_span        (out_span),
		.matched_total   (matched_total),
		.points_dropped  (points_dropped)
	);

	// result payload, zeros on the empty answer come from the datapath
	assign m_tdata = {1'b0, points_dropped, matched_total, out_span.len,
		out_span.d_last, out_span.d_first, out_span.q_last, out_span.q_first};
	assign m_tuser = span_valid;

endmodule

[bench/diagonal_span_chainer_tb.sv]
// ----------------------------------------------------------------------------
// diagonal_span_chainer_tb
// self-checking bench: streams match points in bursts, predicts ranked spans
// per document and compares every result transaction field by field
// ----------------------------------------------------------------------------
module diagonal_span_chainer_tb
	import dsc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 1024;
	localparam int NSPANS = 16;
	localparam int WD_LIMIT = 20000;
	localparam logic [3:0] ADDR_GAP = 4'd0;
	localparam logic [3:0] ADDR_MINLEN = 4'd4;
	localparam logic [3:0] ADDR_MAXSPANS = 4'd8;

	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] qf;
		logic [POS_W-1:0] ql;
		logic [POS_W-1:0] df;
		logic [POS_W-1:0] dl;
		logic [LEN_W-1:0] len;
		logic [TOT_W-1:0] total;
		logic             dropped;
		logic             eol;
	} span_res_t;

	typedef struct {
		logic [POS_W-1:0] q;
		logic [POS_W-1:0] d;
		logic             last;
		logic             typed;   // expected result written in the row
		span_res_t        res;
	} point_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // query_pos[19:0], doc_pos[39:20]
	logic         s_tlast;   // final_point
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // q_first, q_last, d_first, d_last, span_len,
	                         // matched_total, points_dropped, zero pad
	logic         m_tuser;   // span_valid
	logic         m_tlast;   // end_of_list
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	diagonal_span_chainer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [POS_W-1:0] doc_q [NPTS];
	logic [POS_W-1:0] doc_d [NPTS];
	int unsigned      doc_count;
	bit               doc_overflow;
	int unsigned      cfg_gap;
	int unsigned      cfg_minlen;
	int unsigned      cfg_maxspans;
	longint unsigned  sorted_keys [NPTS];
	int unsigned      rank_len [NSPANS];
	int unsigned      rank_qf [NSPANS];
	int unsigned      rank_ql [NSPANS];
	int unsigned      rank_df [NSPANS];
	int unsigned      rank_dl [NSPANS];
	int unsigned      rank_count;

	span_res_t   expected_spans [$];
	int          fail_count;
	int          points_sent;
	int          docs_sent;
	int          spans_seen;
	int          idle_cycles;
	bit          burst_on;
	int          burst_left;

	function automatic bit ahead(int unsigned la, int unsigned qa, int unsigned da,
			int unsigned lb, int unsigned qb, int unsigned db);
		if (la != lb) return la > lb;
		if (qa != qb) return qa < qb;
		return da < db;
	endfunction

	// append one expected result transaction
	function automatic void expect_result(span_res_t r);
		expected_spans = {expected_spans, r};
	endfunction

	// insert one chained span into the ranked list, bounded by limit
	function automatic void rank_span(int unsigned qs, int unsigned qe, int unsigned ds,
			int unsigned de, int unsigned limit);
		int unsigned len;
		int unsigned pos;
		len = (qe - qs + 1) & 32'h1F_FFFF;
		if (len < cfg_minlen || limit == 0) return;
		if (rank_count < limit) begin
			pos = rank_count;
			rank_count++;
		end else begin
			if (!ahead(len, qs, ds, rank_len[limit-1], rank_qf[limit-1], rank_df[limit-1]))
				return;
			pos = limit - 1;
		end
		while (pos > 0 && ahead(len, qs, ds, rank_len[pos-1], rank_qf[pos-1], rank_df[pos-1]))
		begin
			rank_len[pos] = rank_len[pos-1];
			rank_qf[pos] = rank_qf[pos-1];
			rank_ql[pos] = rank_ql[pos-1];
			rank_df[pos] = rank_df[pos-1];
			rank_dl[pos] = rank_dl[pos-1];
			pos--;
		end
		rank_len[pos] = len;
		rank_qf[pos] = qs;
		rank_ql[pos] = qe;
		rank_df[pos] = ds;
		rank_dl[pos] = de;
	endfunction

	// sort by (diagonal, query), chain neighbors, rank and queue the results
	function automatic void chain_document();
		int unsigned limit;
		int unsigned i;
		int unsigned j;
		int unsigned q;
		int unsigned d;
		int unsigned qs, qe, ds, de;
		longint unsigned k;
		longint unsigned diag;
		longint unsigned cur_diag;
		int unsigned total;
		span_res_t r;
		limit = cfg_maxspans > NSPANS ? NSPANS : cfg_maxspans;
		rank_count = 0;
		qs = 0; qe = 0; ds = 0; de = 0; cur_diag = 0;
		for (i = 0; i < doc_count; i++) begin
			k = ((longint'(doc_d[i]) + (64'd1 << 20) - longint'(doc_q[i])) << 20) | doc_q[i];
			j = i;
			while (j > 0 && sorted_keys[j-1] > k) begin
				sorted_keys[j] = sorted_keys[j-1];
				j--;
			end
			sorted_keys[j] = k;
		end
		for (i = 0; i < doc_count; i++) begin
			diag = sorted_keys[i] >> 20;
			q = 32'(sorted_keys[i] & 64'hF_FFFF);
			d = 32'((diag + q - (64'd1 << 20)) & 64'hF_FFFF);
			if (i > 0 && diag == cur_diag && q <= qe + 1 + cfg_gap && d <= de + 1 + cfg_gap)
			begin
				if (q > qe) qe = q;
				if (d > de) de = d;
			end else begin
				if (i > 0) rank_span(qs, qe, ds, de, limit);
				cur_diag = diag;
				qs = q; qe = q; ds = d; de = d;
			end
		end
		if (doc_count > 0) rank_span(qs, qe, ds, de, limit);
		total = 0;
		for (i = 0; i < rank_count; i++) begin
			total += rank_len[i];
			if (total > 32'(TOTAL_CAP)) total = 32'(TOTAL_CAP);
		end
		if (rank_count == 0) begin
			r = '0;
			r.dropped = doc_overflow;
			r.eol = 1'b1;
			expect_result(r);
		end
		for (i = 0; i < rank_count; i++) begin
			r.valid = 1'b1;
			r.qf = POS_W'(rank_qf[i]);
			r.ql = POS_W'(rank_ql[i]);
			r.df = POS_W'(rank_df[i]);
			r.dl = POS_W'(rank_dl[i]);
			r.len = LEN_W'(rank_len[i]);
			r.total = TOT_W'(total);
			r.dropped = doc_overflow;
			r.eol = (i + 1 == rank_count);
			expect_result(r);
		end
	endfunction

	// one point accepted by the block
	function automatic void take_point(logic [POS_W-1:0] q, logic [POS_W-1:0] d, logic last);
		if (doc_count < NPTS) begin
			doc_q[doc_count] = q;
			doc_d[doc_count] = d;
			doc_count++;
		end else begin
			doc_overflow = 1'b1;
		end
		if (last) begin
			chain_document();
			doc_count = 0;
			doc_overflow = 1'b0;
			docs_sent++;
		end
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// every input known from time zero; reset applied once at the start
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// receiver stall pattern: randomly chosen modes, sometimes never stalling
	int stall_mode;
	int stall_age;
	initial begin
		m_tready = 1'b0;
		stall_mode = 0;
		stall_age = 0;
		forever begin
			@(negedge clk);
			if (stall_age == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_age = 64;
			end
			stall_age--;
			case (stall_mode)
				0: m_tready = 1'b1;
				1: m_tready = 1'($urandom_range(0, 1));
				2: m_tready = ($urandom_range(0, 3) == 0);
				default: m_tready = (stall_age % 8) < 5;
			endcase
		end
	end

	// result check: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		span_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			spans_seen++;
			if (expected_spans.size() == 0) begin
				$error("result transaction with nothing expected");
				fail_count++;
			end else begin
				e = expected_spans.pop_front();
				if (m_tuser !== e.valid) begin
					$error("span_valid exp %0d got %0d", e.valid, m_tuser);
					fail_count++;
				end
				if (m_tdata[19:0] !== e.qf) begin
					$error("q_first exp %0h got %0h", e.qf, m_tdata[19:0]);
					fail_count++;
				end
				if (m_tdata[39:20] !== e.ql) begin
					$error("q_last exp %0h got %0h", e.ql, m_tdata[39:20]);
					fail_count++;
				end
				if (m_tdata[59:40] !== e.df) begin
					$error("d_first exp %0h got %0h", e.df, m_tdata[59:40]);
					fail_count++;
				end
				if (m_tdata[79:60] !== e.dl) begin
					$error("d_last exp %0h got %0h", e.dl, m_tdata[79:60]);
					fail_count++;
				end
				if (m_tdata[100:80] !== e.len) begin
					$error("span_len exp %0d got %0d", e.len, m_tdata[100:80]);
					fail_count++;
				end
				if (m_tdata[125:101] !== e.total) begin
					$error("matched_total exp %0d got %0d", e.total, m_tdata[125:101]);
					fail_count++;
				end
				if (m_tdata[126] !== e.dropped) begin
					$error("points_dropped exp %0d got %0d", e.dropped, m_tdata[126]);
					fail_count++;
				end
				if (m_tlast !== e.eol) begin
					$error("end_of_list exp %0d got %0d", e.eol, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles without any accepted transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// register write: setup cycle, then access cycle
	task automatic write_reg(logic [3:0] addr, logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = addr;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			ADDR_GAP: cfg_gap = value & 32'hFF;
			ADDR_MINLEN: cfg_minlen = value & 32'h1F_FFFF;
			default: cfg_maxspans = value & 32'h1F;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// hold the sender until every expected result has arrived, then let the block settle
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_spans.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// one point transaction; bursts of random length with random gaps between them
	task automatic send_point(logic [POS_W-1:0] q, logic [POS_W-1:0] d, logic last,
			bit use_gaps);
		int gap;
		@(negedge clk);
		if (use_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		s_tvalid = 1'b1;
		s_tdata = {d, q};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		points_sent++;
		take_point(q, d, last);
	endtask

	task automatic write_config(int unsigned gap, int unsigned minlen, int unsigned maxs);
		drain();
		write_reg(ADDR_GAP, gap);
		write_reg(ADDR_MINLEN, minlen);
		write_reg(ADDR_MAXSPANS, maxs);
	endtask

	point_row_t directed [$];

	function automatic span_res_t single_span(logic [POS_W-1:0] q, logic [POS_W-1:0] d);
		span_res_t r;
		r.valid = 1'b1;
		r.qf = q; r.ql = q;
		r.df = d; r.dl = d;
		r.len = LEN_W'(1);
		r.total = TOT_W'(1);
		r.dropped = 1'b0;
		r.eol = 1'b1;
		return r;
	endfunction

	function automatic void add_row(logic [POS_W-1:0] q, logic [POS_W-1:0] d, logic last,
			logic typed);
		point_row_t row;
		row.q = q;
		row.d = d;
		row.last = last;
		row.typed = typed;
		row.res = single_span(q, d);
		directed = {directed, row};
	endfunction

	initial begin
		int n;
		int kind;
		int unsigned qb, db;
		int unsigned off;
		fail_count = 0;
		points_sent = 0;
		docs_sent = 0;
		spans_seen = 0;
		idle_cycles = 0;
		burst_left = 0;
		doc_count = 0;
		doc_overflow = 1'b0;
		cfg_gap = 0;
		cfg_minlen = 1;
		cfg_maxspans = 16;

		// directed table; single-point documents at reset settings carry their answer
		add_row(20'h00000, 20'h00000, 1'b1, 1'b1);
		add_row(20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1);
		add_row(20'h00000, 20'hFFFFF, 1'b1, 1'b1);
		add_row(20'hFFFFF, 20'h00000, 1'b1, 1'b1);
		// three adjacent points on one diagonal chain into one span
		add_row(20'd5, 20'd10, 1'b0, 1'b0);
		add_row(20'd6, 20'd11, 1'b0, 1'b0);
		add_row(20'd7, 20'd12, 1'b1, 1'b0);
		// two positions apart on a diagonal: no merge at zero gap
		add_row(20'd5, 20'd10, 1'b0, 1'b0);
		add_row(20'd7, 20'd12, 1'b0, 1'b0);
		add_row(20'd9, 20'd14, 1'b1, 1'b0);
		// duplicates, three diagonals, out of order, ties on length
		add_row(20'd30, 20'd40, 1'b0, 1'b0);
		add_row(20'd30, 20'd40, 1'b0, 1'b0);
		add_row(20'd31, 20'd30, 1'b0, 1'b0);
		add_row(20'd29, 20'd39, 1'b0, 1'b0);
		add_row(20'd30, 20'd29, 1'b0, 1'b0);
		add_row(20'd100, 20'd7, 1'b1, 1'b0);

		wait (arst_n);
		write_config(0, 1, 16);
		foreach (directed[i]) begin
			send_point(directed[i].q, directed[i].d, directed[i].last, 1'b0);
			if (directed[i].typed) begin
				expected_spans[expected_spans.size() - 1] = directed[i].res;
			end
		end

		// no span kept: max_spans zero, then a minimum longer than any span
		write_config(255, 0, 0);
		send_point(20'd3, 20'd3, 1'b0, 1'b0);
		send_point(20'd4, 20'd4, 1'b1, 1'b0);
		write_config(255, 1048576, 31);
		send_point(20'd3, 20'd3, 1'b0, 1'b0);
		send_point(20'd9, 20'd9, 1'b1, 1'b0);

		// store overflow: identical points keep the sort short, the final one is lost too
		write_config(0, 1, 31);
		for (int i = 0; i < NPTS + 6; i++)
			send_point(20'd100, 20'd200, i == NPTS + 5, 1'b1);

		// random documents: mostly clustered near a few diagonals, some pure noise
		while (points_sent < NPTS + 30 + 270) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0: write_config($urandom_range(0, 255), $urandom_range(0, 6),
						$urandom_range(0, 31));
					1: write_config(255, $urandom_range(0, 1) ? 0 : 1048576, 16);
					2: write_config(0, 1, $urandom_range(0, 1));
					default: write_config($urandom_range(0, 4), $urandom_range(1, 3),
						$urandom_range(2, 20));
				endcase
			end else if ($urandom_range(0, 9) == 0) begin
				drain();   // sender holds off until the block has answered everything
			end
			n = $urandom_range(1, 24);
			kind = $urandom_range(0, 4);
			qb = $urandom_range(0, 20'hFFFFF - 64);
			db = $urandom_range(0, 20'hFFFFF - 64);
			for (int i = 0; i < n; i++) begin
				if (kind == 0) begin
					send_point(POS_W'($urandom), POS_W'($urandom), i == n - 1, 1'b1);
				end else begin
					off = $urandom_range(0, 40);
					send_point(POS_W'(qb + off),
						POS_W'(db + off + ($urandom_range(0, 5) == 0 ? kind : 0)),
						i == n - 1, 1'b1);
				end
			end
		end

		drain();
		repeat (50) @(negedge clk);
		$display("covered %0d points in %0d documents, %0d result transactions checked",
			points_sent, docs_sent, spans_seen);
		$display("includes empty answers, store overflow and every register at its extremes");
		if (fail_count == 0 && expected_spans.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/dsc_pkg.sv
rtl/core/dsc_ram.sv
rtl/core/dsc_span_list.sv
rtl/core/dsc_datapath.sv
rtl/core/dsc_ctrl.sv
rtl/core/diagonal_span_chainer.sv
bench/diagonal_span_chainer_tb.sv
